[design/itn_pkg.sv]
package itn_pkg;

   localparam int KIND_W    = 3;
   localparam int OPERAND_W = 16;
   localparam int INDEX_W   = 6;

   localparam logic REQ_INTERN = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   typedef struct packed {
      logic                 req_type;
      logic [KIND_W-1:0]    kind;
      logic [OPERAND_W-1:0] left;
      logic [OPERAND_W-1:0] right;
      logic [INDEX_W-1:0]   entry_index;
   } itn_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]   result_index;
      logic                 table_full;
      logic                 was_present;
      logic                 entry_valid;
      logic [KIND_W-1:0]    entry_kind;
      logic [OPERAND_W-1:0] entry_left;
      logic [OPERAND_W-1:0] entry_right;
   } itn_rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [OPERAND_W-1:0] left;
      logic [OPERAND_W-1:0] right;
   } itn_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_FINISH
   } itn_state_type;

endpackage

[design/intern_table_find_or_insert.sv]
// Channel   Ports                          Direction  Carries
// request   req_valid req_stall req_item   in         intern or read item
// response  rsp_valid rsp_stall rsp_item   out        one result item per request
//
// One item at a time. A read passes through ST_READ and ST_FINISH to rsp_valid, or goes
// straight to ST_FINISH when the index lies beyond the filled entries. An intern scans
// the filled entries, at most TABLE_ENTRIES, through the single read port, one entry per
// cycle. The next item can be taken in the cycle in which rsp_valid rises.
// Entries fill in order and are never freed, so a fill count replaces valid bits.
// Reset empties the table at once. The result register lets rsp_stall hold a
// result while the next request is taken and worked on.
module intern_table_find_or_insert #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  itn_pkg::itn_req_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output itn_pkg::itn_rsp_type rsp_item
);
   import itn_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   itn_state_type state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] tag_ff, tag_in;
   itn_entry_type    key_ff, key_in;
   itn_rsp_type      res_ff, res_in;
   itn_rsp_type      rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   itn_entry_type    rd_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   itn_entry_type    wr_data;

   itn_entry_type    req_key;
   itn_rsp_type      miss_res;
   logic             full;
   logic             last;
   logic             match;
   logic [CMP_W-1:0] rd_idx_ext;

   itn_store #(
      .DEPTH (TABLE_ENTRIES)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_key.kind  = req_item.kind;
   assign req_key.left  = req_item.left;
   assign req_key.right = req_item.right;

   assign full       = (fill_ff == CNT_W'(TABLE_ENTRIES));
   assign last       = ((CNT_W'(tag_ff) + CNT_W'(1)) == fill_ff);
   assign match      = (rd_data == key_ff);
   assign rd_idx_ext = CMP_W'(req_item.entry_index);

   // result when no entry matched: insert at the fill point, or report full
   always_comb begin
      miss_res = '0;
      if (full) begin
         miss_res.table_full = 1'b1;
      end else begin
         miss_res.result_index = INDEX_W'(fill_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      tag_in       = tag_ff;
      key_in       = key_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;
      wr_en        = 1'b0;
      wr_addr      = fill_ff[IDX_W-1:0];
      wr_data      = key_ff;
      req_stall    = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in = req_key;
               if (req_item.req_type == REQ_READ) begin
                  if (rd_idx_ext < CMP_W'(fill_ff)) begin
                     rd_en    = 1'b1;
                     rd_addr  = rd_idx_ext[IDX_W-1:0];
                     state_in = ST_READ;
                  end else begin
                     res_in   = '0;
                     state_in = ST_FINISH;
                  end
               end else if (fill_ff == '0) begin
                  wr_en    = 1'b1;
                  wr_data  = req_key;
                  res_in   = miss_res;
                  fill_in  = fill_ff + CNT_W'(1);
                  state_in = ST_FINISH;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  tag_in   = '0;
                  ptr_in   = IDX_W'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_en  = 1'b1;
            ptr_in = ptr_ff + IDX_W'(1);
            tag_in = ptr_ff;
            if (match) begin
               res_in              = '0;
               res_in.result_index = INDEX_W'(tag_ff);
               res_in.was_present  = 1'b1;
               state_in            = ST_FINISH;
            end else if (last) begin
               res_in = miss_res;
               if (!full) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + CNT_W'(1);
               end
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            res_in             = '0;
            res_in.entry_valid = 1'b1;
            res_in.entry_kind  = rd_data.kind;
            res_in.entry_left  = rd_data.left;
            res_in.entry_right = rd_data.right;
            state_in           = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      tag_ff <= tag_in;
      key_ff <= key_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (fill_ff != $past(fill_ff))) |-> (fill_ff == $past(fill_ff) + CNT_W'(1)))
      else $error("fill count moved by more than one");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CNT_W'(tag_ff) < fill_ff))
      else $error("scan beyond filled entries");

   a_full_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.table_full) |-> full)
      else $error("table full reported with a free entry");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.was_present) |->
      (!rsp_ff.table_full && (CMP_W'(rsp_ff.result_index) < CMP_W'(fill_ff))))
      else $error("hit index outside filled entries");

endmodule

[design/itn_store.sv]
module itn_store #(
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output itn_pkg::itn_entry_type              rd_data,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  itn_pkg::itn_entry_type              wr_data
);
   import itn_pkg::*;

   itn_entry_type mem [DEPTH];
   itn_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import itn_pkg::*;

   localparam int SLOTS      = 64;
   localparam int RANDOM_N   = 900;
   localparam int QUIET_MAX  = 3000;
   localparam int DRAIN_CYC  = 70;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   itn_req_type req_item = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   itn_rsp_type rsp_item;

   intern_table_find_or_insert dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #2 clock = ~clock;

   // table as the block should hold it
   bit            held_used [SLOTS];
   itn_entry_type held_entry[SLOTS];

   itn_req_type   pending_req[$];
   itn_rsp_type   expected_rsp[$];
   itn_entry_type asked[$];        // distinct triples queued for interning so far, in order

   int n_items = 1;
   int n_accepted = 0;
   int n_results = 0;
   int n_mismatch = 0;
   int n_inserts = 0, n_hits = 0, n_full = 0, n_reads = 0;
   int quiet = 0;

   function automatic bit roll(int pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic int phase_now();
      return (n_accepted * 4) / n_items;
   endfunction

   function automatic int send_idle_pct();
      case (phase_now())
         1: return 63;
         3: return 35;
         default: return 0;
      endcase
   endfunction

   function automatic int stall_pct();
      case (phase_now())
         2: return 63;
         3: return 35;
         default: return 0;
      endcase
   endfunction

   function automatic itn_rsp_type intern_or_read(itn_req_type rq);
      itn_rsp_type r;
      int hit;
      int spare;
      r = '0;
      hit = -1;
      spare = -1;
      if (rq.req_type == REQ_READ) begin
         n_reads++;
         if (held_used[rq.entry_index]) begin
            r.entry_valid = 1'b1;
            r.entry_kind  = held_entry[rq.entry_index].kind;
            r.entry_left  = held_entry[rq.entry_index].left;
            r.entry_right = held_entry[rq.entry_index].right;
         end
         return r;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (held_used[i]) begin
            if (hit < 0 && held_entry[i].kind == rq.kind && held_entry[i].left == rq.left
                && held_entry[i].right == rq.right)
               hit = i;
         end else if (spare < 0) begin
            spare = i;
         end
      end
      if (hit >= 0) begin
         n_hits++;
         r.result_index = hit[INDEX_W-1:0];
         r.was_present  = 1'b1;
      end else if (spare >= 0) begin
         n_inserts++;
         held_used[spare]        = 1'b1;
         held_entry[spare].kind  = rq.kind;
         held_entry[spare].left  = rq.left;
         held_entry[spare].right = rq.right;
         r.result_index = spare[INDEX_W-1:0];
      end else begin
         n_full++;
         r.table_full = 1'b1;
      end
      return r;
   endfunction

   task automatic flag(string what, longint unsigned want, longint unsigned got);
      n_mismatch++;
      if (n_mismatch <= 10)
         $display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
   endtask

   function automatic bit asked_before(itn_entry_type e);
      foreach (asked[i])
         if (asked[i] == e)
            return 1'b1;
      return 1'b0;
   endfunction

   function automatic int stored_count();
      return asked.size() < SLOTS ? asked.size() : SLOTS;
   endfunction

   task automatic queue_intern(itn_entry_type e);
      itn_req_type rq;
      rq.req_type    = REQ_INTERN;
      rq.kind        = e.kind;
      rq.left        = e.left;
      rq.right       = e.right;
      rq.entry_index = $urandom_range(SLOTS - 1);
      if (!asked_before(e))
         asked.push_back(e);
      pending_req.push_back(rq);
   endtask

   // the slot index is read as given, filled or not; the other fields are noise
   task automatic queue_read(int idx);
      itn_req_type rq;
      rq.req_type    = REQ_READ;
      rq.kind        = $urandom_range(7);
      rq.left        = $urandom;
      rq.right       = $urandom;
      rq.entry_index = idx;
      pending_req.push_back(rq);
   endtask

   function automatic itn_entry_type triple(int k, int l, int r);
      itn_entry_type e;
      e.kind  = k;
      e.left  = l;
      e.right = r;
      return e;
   endfunction

   function automatic logic [OPERAND_W-1:0] edgy_operand();
      case ($urandom_range(2))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // a triple never interned before: random, extreme, or one field off a known one
   function automatic itn_entry_type fresh_triple();
      itn_entry_type e;
      do begin
         case ($urandom_range(2))
            0: e = triple($urandom_range(7), $urandom, $urandom);
            1: e = triple($urandom_range(1) ? 7 : 0, edgy_operand(), edgy_operand());
            default: begin
               e = asked.size() != 0 ? asked[$urandom_range(asked.size() - 1)]
                                     : triple(0, 0, 0);
               case ($urandom_range(2))
                  0: e.kind  = e.kind ^ (3'd1 << $urandom_range(KIND_W - 1));
                  1: e.left  = e.left ^ (16'd1 << $urandom_range(OPERAND_W - 1));
                  default: e.right = e.right ^ (16'd1 << $urandom_range(OPERAND_W - 1));
               endcase
            end
         endcase
      end while (asked_before(e));
      return e;
   endfunction

   // driver
   always @(posedge clock) begin
      itn_rsp_type want;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            want = intern_or_read(req_item);
            expected_rsp.push_back(want);
            n_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_req.size() != 0 && !roll(send_idle_pct())) begin
               req_item  <= pending_req.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      itn_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (expected_rsp.size() == 0) begin
               flag("item with nothing awaited", 0, rsp_item);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_item.result_index !== want.result_index)
                  flag("result_index", want.result_index, rsp_item.result_index);
               if (rsp_item.table_full !== want.table_full)
                  flag("table_full", want.table_full, rsp_item.table_full);
               if (rsp_item.was_present !== want.was_present)
                  flag("was_present", want.was_present, rsp_item.was_present);
               if (rsp_item.entry_valid !== want.entry_valid)
                  flag("entry_valid", want.entry_valid, rsp_item.entry_valid);
               if (rsp_item.entry_kind !== want.entry_kind)
                  flag("entry_kind", want.entry_kind, rsp_item.entry_kind);
               if (rsp_item.entry_left !== want.entry_left)
                  flag("entry_left", want.entry_left, rsp_item.entry_left);
               if (rsp_item.entry_right !== want.entry_right)
                  flag("entry_right", want.entry_right, rsp_item.entry_right);
            end
         end
         rsp_stall <= roll(stall_pct());
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_MAX) begin
         $display("[%0t] no item moved for %0d cycles", $time, QUIET_MAX);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      // directed: extremes, hits, one-field near misses, reads
      queue_intern(triple(0, 16'h0000, 16'h0000));
      queue_intern(triple(7, 16'hffff, 16'hffff));
      queue_intern(triple(0, 16'h0000, 16'h0000));
      queue_intern(triple(7, 16'hffff, 16'hffff));
      queue_intern(triple(1, 16'h0000, 16'h0000));
      queue_intern(triple(0, 16'h0001, 16'h0000));
      queue_intern(triple(0, 16'h0000, 16'h0001));
      queue_intern(triple(0, 16'h8000, 16'h0000));
      queue_intern(triple(0, 16'h0000, 16'h8000));
      queue_intern(triple(4, 16'h0000, 16'h0000));
      queue_intern(triple(7, 16'hffff, 16'hfffe));
      queue_intern(triple(3, 16'h5555, 16'haaaa));
      queue_intern(triple(1, 16'h0000, 16'h0000));
      queue_intern(triple(0, 16'h0000, 16'h8000));
      queue_read(0);
      queue_read(1);
      queue_read(7);
      queue_read(11);
      queue_intern(triple(3, 16'h5555, 16'haaaa));
      queue_read(4);

      // random: mostly repeats of known triples so the table fills gradually
      for (int n = 0; n < RANDOM_N; n++) begin
         if (asked.size() != 0 && roll(25))
            queue_read($urandom_range(stored_count() - 1));
         else if (asked.size() == 0 || roll(15))
            queue_intern(fresh_triple());
         else
            queue_intern(asked[$urandom_range(asked.size() - 1)]);
      end
      n_items = pending_req.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do
         @(posedge clock);
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0);
      repeat (DRAIN_CYC) @(posedge clock);
      if (expected_rsp.size() != 0)
         flag("items still awaited", 0, expected_rsp.size());

      $display("%0d items sent, %0d results checked, %0d mismatches", n_accepted, n_results,
               n_mismatch);
      $display("%0d inserts, %0d hits, %0d refused with table full, %0d reads", n_inserts,
               n_hits, n_full, n_reads);
      if (n_mismatch == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
